[rtl/core/ufca_pkg.sv]
// shared types and constants for the undervoltage flag and current average block
package ufca_pkg;

    localparam int WINDOW  = 10;
    localparam int DEV_W   = 5;
    localparam int VOLT_W  = 9;
    localparam int CUR_W   = 12;
    localparam int ERR_W   = 16;
    localparam int SUM_W   = 16;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    localparam logic [VOLT_W-1:0] LIMIT_RESET = VOLT_W'(200);

    // reciprocal for the mean: floor(x / WINDOW) == (x * RECIP) >> RECIP_SHIFT for any SUM_W-bit x
    localparam int          RECIP_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int          RECIP_W     = SUM_W + 2;
    localparam longint      RECIP_FULL  = ((64'd1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int          PROD_W      = SUM_W + RECIP_W;

    // one slot of the sample line
    typedef struct packed {
        logic             full;
        logic [CUR_W-1:0] data;
    } cell_t;

endpackage

[rtl/core/ufca_cell.sv]
// one slot of the current sample line, shifts toward the oldest end on each beat
module ufca_cell
    import ufca_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift_en,
    input  cell_t prev,
    output cell_t q
);

    cell_t slot_reg;
    cell_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (shift_en)
        begin
            slot_next = prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign q = slot_reg;

endmodule

[rtl/core/undervoltage_flag_and_current_average_top.sv]
// top level: undervoltage flag, error count and moving average of current
// Takes one record per clock and gives one result per record through stage a and
// stage b; a full rate stream is sustained while the output side keeps
// tready high. Samples move down a line of WINDOW cells with a running sum that
// is updated at the input beat; the next stage turns the sum into the mean with a
// reciprocal multiply and registers the result. average_valid rises on the
// WINDOW-th record after reset, and average_current reads zero until then.
// The limit register resets to 200 and is written through the cfg channel.
module undervoltage_flag_and_current_average_top
    import ufca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [VOLT_W-1:0]      cfg_data,      // low_voltage_limit
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,       // device_number, voltage, current
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,       // error_number, device_echo, voltage_echo, average_current
    output logic [OUT_TUSER_W-1:0] m_tuser        // undervoltage, average_valid
);

    logic [DEV_W-1:0]  s_dev;
    logic [VOLT_W-1:0] s_volt;
    logic [CUR_W-1:0]  s_cur;

    assign s_dev  = s_tdata[DEV_W-1:0];
    assign s_volt = s_tdata[DEV_W +: VOLT_W];
    assign s_cur  = s_tdata[DEV_W+VOLT_W +: CUR_W];

    logic [VOLT_W-1:0] limit_reg;
    logic [VOLT_W-1:0] limit_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end
    end

    // pipeline handshake
    logic a_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s_accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // sample line
    cell_t chain_q [WINDOW];

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            cell_t prev_in;
            if (gi == 0)
            begin : g_head
                assign prev_in = '{full: 1'b1, data: s_cur};
            end
            else
            begin : g_link
                assign prev_in = chain_q[gi-1];
            end
            ufca_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (s_accept),
                .prev     (prev_in),
                .q        (chain_q[gi])
            );
        end
    endgenerate

    // running state
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [ERR_W-1:0] err_reg;
    logic [ERR_W-1:0] err_next;
    logic             flag;

    assign flag = (s_volt < limit_reg);

    always_comb
    begin
        sum_next = sum_reg;
        err_next = err_reg;
        if (s_accept)
        begin
            sum_next = sum_reg - SUM_W'(chain_q[WINDOW-1].data) + SUM_W'(s_cur);
            if (flag)
            begin
                err_next = err_reg + ERR_W'(1);
            end
        end
    end

    // stage a: record and running sum
    logic              a_valid_next;
    logic              a_flag_reg;
    logic [ERR_W-1:0]  a_err_reg;
    logic [DEV_W-1:0]  a_dev_reg;
    logic [VOLT_W-1:0] a_volt_reg;
    logic              a_avgv_reg;
    logic [SUM_W-1:0]  a_sum_reg;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (s_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            a_valid_next = 1'b0;
        end
    end

    // stage b: mean and output register
    logic                  out_valid_next;
    logic [PROD_W-1:0]     prod;
    logic [CUR_W-1:0]      mean;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;
    logic                  b_load;

    assign prod   = PROD_W'(a_sum_reg) * PROD_W'(RECIP);
    assign mean   = a_avgv_reg ? prod[RECIP_SHIFT +: CUR_W] : '0;
    assign b_load = a_valid_reg && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (b_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            sum_reg       <= '0;
            err_reg       <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            sum_reg       <= sum_next;
            err_reg       <= err_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_flag_reg <= flag;
            a_err_reg  <= err_next;
            a_dev_reg  <= s_dev;
            a_volt_reg <= s_volt;
            // line is full after this beat once the second to last slot already holds a sample
            a_avgv_reg <= chain_q[WINDOW-2].full;
            a_sum_reg  <= sum_next;
        end
        if (b_load)
        begin
            out_data_reg <= {6'd0, mean, a_volt_reg, a_dev_reg, a_err_reg};
            out_user_reg <= {a_avgv_reg, a_flag_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef ASSERT_OFF
    a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && flag |=> err_reg == $past(err_reg) + ERR_W'(1))
        else $error("error count did not advance on a flagged beat");

    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_accept && flag) |=> $stable(err_reg))
        else $error("error count moved without a flagged beat");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !out_free |=> a_valid_reg && $stable(a_sum_reg))
        else $error("stage a dropped a record while the output was stalled");

    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[41:30] == '0)
        else $error("mean shown before the window filled");
`endif

endmodule

[sim/undervoltage_flag_and_current_average_top_test.sv]
// testbench for the undervoltage flag, error count and moving current average block
`timescale 1ns / 1ps

module undervoltage_flag_and_current_average_top_test;
    import ufca_pkg::*;

    typedef struct {
        logic              undervoltage;
        logic [ERR_W-1:0]  error_number;
        logic [DEV_W-1:0]  device_echo;
        logic [VOLT_W-1:0] voltage_echo;
        logic              average_valid;
        logic [CUR_W-1:0]  average_current;
    } sensor_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [VOLT_W-1:0]      cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    // predictor state
    logic [CUR_W-1:0]  sample_ring [WINDOW];
    int                ring_slot;
    int                samples_held;
    logic [SUM_W-1:0]  ring_total;
    logic [ERR_W-1:0]  undervolt_count;
    logic [VOLT_W-1:0] low_limit;

    sensor_result_t pending_results [$];
    int             fail_count = 0;
    bit             source_idles = 1'b1;
    bit             sink_idles = 1'b1;
    int             sink_hold_cycles = 0;

    undervoltage_flag_and_current_average_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // expected result of one record, advancing the predictor state
    task automatic predict_record(input logic [DEV_W-1:0] dev, input logic [VOLT_W-1:0] volt,
                                  input logic [CUR_W-1:0] cur);
        sensor_result_t res;
        res.undervoltage = (volt < low_limit);
        if (res.undervoltage)
            undervolt_count = undervolt_count + 1'b1;
        ring_total = ring_total - sample_ring[ring_slot] + cur;
        sample_ring[ring_slot] = cur;
        ring_slot = (ring_slot + 1) % WINDOW;
        if (samples_held < WINDOW)
            samples_held++;
        res.error_number = undervolt_count;
        res.device_echo = dev;
        res.voltage_echo = volt;
        res.average_valid = (samples_held >= WINDOW);
        res.average_current = res.average_valid ? CUR_W'(ring_total / WINDOW) : '0;
        pending_results.push_back(res);
    endtask

    task automatic send_record(input logic [DEV_W-1:0] dev, input logic [VOLT_W-1:0] volt,
                               input logic [CUR_W-1:0] cur);
        if (source_idles)
            while ($urandom_range(99) < 26)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, cur, volt, dev};
        do
            @(posedge clk);
        while (!s_tready);
        predict_record(dev, volt, cur);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [VOLT_W-1:0] limit);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= limit;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        low_limit = limit;
    endtask

    // receiver: random stalls, a counted hold-off when one is requested, or always ready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                sink_hold_cycles--;
            end
            else if (sink_idles)
                m_tready <= ($urandom_range(99) >= 26);
            else
                m_tready <= 1'b1;
        end
    end

    // compare every result beat with the oldest expectation
    always @(posedge clk)
    begin
        sensor_result_t exp_res;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tuser[0] !== exp_res.undervoltage)
                begin
                    $error("undervoltage expected %0d got %0d", exp_res.undervoltage, m_tuser[0]);
                    fail_count++;
                end
                if (m_tdata[15:0] !== exp_res.error_number)
                begin
                    $error("error_number expected %0d got %0d", exp_res.error_number,
                           m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[20:16] !== exp_res.device_echo)
                begin
                    $error("device_echo expected %0d got %0d", exp_res.device_echo,
                           m_tdata[20:16]);
                    fail_count++;
                end
                if (m_tdata[29:21] !== exp_res.voltage_echo)
                begin
                    $error("voltage_echo expected %0d got %0d", exp_res.voltage_echo,
                           m_tdata[29:21]);
                    fail_count++;
                end
                if (m_tuser[1] !== exp_res.average_valid)
                begin
                    $error("average_valid expected %0d got %0d", exp_res.average_valid,
                           m_tuser[1]);
                    fail_count++;
                end
                if (m_tdata[41:30] !== exp_res.average_current)
                begin
                    $error("average_current expected %0d got %0d", exp_res.average_current,
                           m_tdata[41:30]);
                    fail_count++;
                end
            end
        end
    end

    // reset limit, both sides of the threshold, window fill and a full-scale window
    task automatic test_reset_and_window_fill();
        send_record(5'd0, 9'd199, 12'd0);
        send_record(5'd31, 9'd200, 12'd4095);
        send_record(5'd1, 9'd0, 12'd4095);
        send_record(5'd30, 9'd511, 12'd0);
        send_record(5'd20, 9'd198, 12'd1);
        send_record(5'd10, 9'd201, 12'd2048);
        send_record(5'd21, 9'd255, 12'd3000);
        send_record(5'd15, 9'd180, 12'd7);
        send_record(5'd16, 9'd260, 12'd9);
        // tenth record makes the window full
        send_record(5'd2, 9'd220, 12'd4094);
        send_record(5'd3, 9'd100, 12'd11);
        repeat (WINDOW)
            send_record(5'($urandom_range(31)), 9'($urandom_range(511)), 12'd4095);
    endtask

    task automatic test_limit_extremes();
        write_limit(9'd0);
        send_record(5'd4, 9'd0, 12'd0);
        send_record(5'd5, 9'd511, 12'd0);
        write_limit(9'd511);
        send_record(5'd6, 9'd510, 12'd0);
        send_record(5'd7, 9'd511, 12'd0);
        send_record(5'd8, 9'd0, 12'd0);
        write_limit(9'd1);
        send_record(5'd9, 9'd0, 12'd4095);
        send_record(5'd9, 9'd1, 12'd4095);
    endtask

    // a long run of flagged records, full rate on both sides
    task automatic test_full_rate_flagged();
        write_limit(9'd511);
        source_idles = 1'b0;
        sink_idles = 1'b0;
        repeat (200)
            send_record(5'($urandom_range(31)), 9'($urandom_range(510)),
                        12'($urandom_range(4095)));
        wait_for_results();
        source_idles = 1'b1;
        sink_idles = 1'b1;
    endtask

    // receiver holds off while records keep coming, so the input stalls
    task automatic test_output_hold_off();
        write_limit(9'd200);
        sink_hold_cycles = 300;
        repeat (40)
            send_record(5'($urandom_range(31)), 9'($urandom_range(150, 250)),
                        12'($urandom_range(4095)));
        wait_for_results();
    endtask

    task automatic test_random_records();
        logic [VOLT_W-1:0] limit;
        logic [VOLT_W-1:0] volt;
        logic [CUR_W-1:0]  cur;
        int                pick;
        int                near;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       limit = 9'd511;
                1:       limit = 9'd0;
                default: limit = 9'($urandom_range(511));
            endcase
            write_limit(limit);
            for (int n = 0; n < 280; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    // hover around the threshold
                    near = int'(limit) + $urandom_range(6) - 3;
                    volt = (near < 0) ? 9'd0 : (near > 511) ? 9'd511 : 9'(near);
                end
                else
                    volt = 9'($urandom_range(511));
                pick = $urandom_range(99);
                if (pick < 10)
                    cur = '0;
                else if (pick < 20)
                    cur = '1;
                else
                    cur = 12'($urandom_range(4095));
                send_record(5'($urandom_range(31)), volt, cur);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < WINDOW; i++)
            sample_ring[i] = '0;
        ring_slot = 0;
        samples_held = 0;
        ring_total = '0;
        undervolt_count = '0;
        low_limit = LIMIT_RESET;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_and_window_fill();
        test_limit_extremes();
        test_full_rate_flagged();
        test_output_hold_off();
        test_random_records();

        wait_for_results();
        repeat (10)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
